FILE: hdl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, request and status codes, and the RAM control bundle for the
// bounded deque with search and erase.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH      = 16;   // power of two: slot arithmetic wraps by mask
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_COUNT      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_ERASE      = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        word_t             wr_data;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } ram_ctl_t;

endpackage

FILE: hdl/bdq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: operation code and operand value with valid/ready.
// ----------------------------------------------------------------------------
interface bdq_req_if;

    logic                              valid;
    logic                              ready;
    logic [bdq_pkg::FUNC_W-1:0]        func;
    logic signed [bdq_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);

endinterface

FILE: hdl/bdq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: result, status and store summary with valid/ready.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [bdq_pkg::DATA_WIDTH-1:0] result_value;
    logic [bdq_pkg::STATUS_W-1:0]          status;
    logic [bdq_pkg::CNT_W-1:0]             fill_level;
    logic signed [bdq_pkg::DATA_WIDTH-1:0] front_value;
    logic signed [bdq_pkg::DATA_WIDTH-1:0] back_value;
    logic                                  is_empty;

    modport source (output valid, output result_value, output status, output fill_level,
                    output front_value, output back_value, output is_empty, input ready);
    modport sink   (input valid, input result_value, input status, input fill_level,
                    input front_value, input back_value, input is_empty, output ready);

endinterface

FILE: hdl/bdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Entry storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram (
    input  logic              clk,
    input  bdq_pkg::ram_ctl_t ctl,
    output bdq_pkg::word_t    rd_data_a,
    output bdq_pkg::word_t    rd_data_b
);

    bdq_pkg::word_t mem [bdq_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_data_a <= mem[ctl.rd_addr_a];
        rd_data_b <= mem[ctl.rd_addr_b];
    end

endmodule

FILE: hdl/bounded_deque_with_search_erase_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_erase_top
// Circular-buffer deque with push/pop at both ends, match count and
// erase-first-match, run by a small sequencer over one shared comparator.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+-------------------------------------------------------------
//  req     | in  | func[2:0], value[31:0]
//  rsp     | out | result_value[31:0], status[1:0], fill_level[4:0],
//          |     | front_value[31:0], back_value[31:0], is_empty
//
//  Scan and gap shift together step one entry per cycle through the registered
//  RAM read; a new request is taken only once the last has reached the output register.
//  Reset clears head, count and control; the RAM itself is not cleared.
//  A stalled response holds in the output register; the next request is taken
//  meanwhile and waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_erase_top (
    input  logic  clk,
    input  logic  rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EXEC     = 7'b0000010,
        ST_POP_WAIT = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_SHIFT    = 7'b0010000,
        ST_FETCH    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    localparam logic [bdq_pkg::CNT_W-1:0] CNT_ONE  = bdq_pkg::CNT_W'(1);
    localparam logic [bdq_pkg::CNT_W-1:0] CNT_TWO  = bdq_pkg::CNT_W'(2);
    localparam logic [bdq_pkg::CNT_W-1:0] CNT_FULL = bdq_pkg::CNT_W'(bdq_pkg::DEPTH);

    state_t                          state_reg,  state_next;
    logic [bdq_pkg::FUNC_W-1:0]      func_reg,   func_next;
    bdq_pkg::word_t                  value_reg,  value_next;
    logic [bdq_pkg::ADDR_W-1:0]      head_reg,   head_next;
    logic [bdq_pkg::CNT_W-1:0]       count_reg,  count_next;
    logic [bdq_pkg::ADDR_W-1:0]      idx_reg,    idx_next;
    logic [bdq_pkg::CNT_W-1:0]       hits_reg,   hits_next;
    bdq_pkg::word_t                  result_reg, result_next;
    logic [bdq_pkg::STATUS_W-1:0]    status_reg, status_next;

    logic                            out_valid_reg,  out_valid_next;
    bdq_pkg::word_t                  out_result_reg, out_result_next;
    logic [bdq_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [bdq_pkg::CNT_W-1:0]       out_fill_reg,   out_fill_next;
    bdq_pkg::word_t                  out_front_reg,  out_front_next;
    bdq_pkg::word_t                  out_back_reg,   out_back_next;
    logic                            out_empty_reg,  out_empty_next;

    bdq_pkg::ram_ctl_t               ram_ctl;
    bdq_pkg::word_t                  rd_data_a;
    bdq_pkg::word_t                  rd_data_b;

    logic                            req_xfer;
    logic                            store_full;
    logic                            store_empty;
    logic                            match;
    logic                            last;
    logic [bdq_pkg::CNT_W-1:0]       idx_ext;

    // physical slot of a logical offset from the front
    function automatic logic [bdq_pkg::ADDR_W-1:0] slot_of(
        input logic [bdq_pkg::ADDR_W-1:0] head,
        input logic [bdq_pkg::CNT_W-1:0]  offset
    );
        return head + offset[bdq_pkg::ADDR_W-1:0];
    endfunction

    bdq_ram u_ram (
        .clk       (clk),
        .ctl       (ram_ctl),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign req.ready    = (state_reg == ST_IDLE);
    assign req_xfer     = req.valid && req.ready;
    assign store_full   = (count_reg == CNT_FULL);
    assign store_empty  = (count_reg == '0);
    assign idx_ext      = bdq_pkg::CNT_W'(idx_reg);
    assign match        = (rd_data_a == value_reg);
    assign last         = (idx_ext == count_reg - CNT_ONE);

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_result_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.fill_level   = out_fill_reg;
    assign rsp.front_value  = out_front_reg;
    assign rsp.back_value   = out_back_reg;
    assign rsp.is_empty     = out_empty_reg;

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hits_next   = hits_reg;
        result_next = result_reg;
        status_next = status_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_result_next = out_result_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_empty_next  = out_empty_reg;

        ram_ctl.wr_en     = 1'b0;
        ram_ctl.wr_addr   = slot_of(head_reg, count_reg);
        ram_ctl.wr_data   = value_reg;
        ram_ctl.rd_addr_a = head_reg;
        ram_ctl.rd_addr_b = slot_of(head_reg, count_reg - CNT_ONE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    func_next   = req.func;
                    value_next  = req.value;
                    status_next = bdq_pkg::STATUS_OK;
                    result_next = '0;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                idx_next   = '0;
                hits_next  = '0;
                state_next = ST_FETCH;
                unique case (func_reg)
                    bdq_pkg::FUNC_PUSH_FRONT:
                    begin
                        if (store_full)
                        begin
                            status_next = bdq_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            ram_ctl.wr_en   = 1'b1;
                            ram_ctl.wr_addr = head_reg - 1'b1;
                            head_next       = head_reg - 1'b1;
                            count_next      = count_reg + CNT_ONE;
                        end
                    end
                    bdq_pkg::FUNC_PUSH_BACK:
                    begin
                        if (store_full)
                        begin
                            status_next = bdq_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            ram_ctl.wr_en = 1'b1;
                            count_next    = count_reg + CNT_ONE;
                        end
                    end
                    bdq_pkg::FUNC_POP_FRONT,
                    bdq_pkg::FUNC_POP_BACK:
                    begin
                        if (store_empty)
                        begin
                            status_next = bdq_pkg::STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            if (func_reg == bdq_pkg::FUNC_POP_BACK)
                            begin
                                ram_ctl.rd_addr_a = slot_of(head_reg, count_reg - CNT_ONE);
                            end
                            state_next = ST_POP_WAIT;
                        end
                    end
                    bdq_pkg::FUNC_COUNT,
                    bdq_pkg::FUNC_ERASE:
                    begin
                        if (store_empty)
                        begin
                            if (func_reg == bdq_pkg::FUNC_ERASE)
                            begin
                                status_next = bdq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        // unused selector: no operation
                    end
                endcase
            end

            ST_POP_WAIT:
            begin
                result_next = rd_data_a;
                count_next  = count_reg - CNT_ONE;
                if (func_reg == bdq_pkg::FUNC_POP_FRONT)
                begin
                    head_next = head_reg + 1'b1;
                end
                state_next = ST_FETCH;
            end

            ST_SCAN:
            begin
                // rd_data_a holds the entry at logical offset idx
                ram_ctl.rd_addr_a = slot_of(head_reg, idx_ext + CNT_ONE);
                if (func_reg == bdq_pkg::FUNC_COUNT)
                begin
                    if (match)
                    begin
                        hits_next = hits_reg + CNT_ONE;
                    end
                    if (last)
                    begin
                        result_next = bdq_pkg::DATA_WIDTH'(hits_next);
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (match)
                begin
                    if (last)
                    begin
                        count_next = count_reg - CNT_ONE;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (last)
                begin
                    status_next = bdq_pkg::STATUS_NOT_FOUND;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_SHIFT:
            begin
                // move entry idx+1 (now in rd_data_a) down to idx, prefetch idx+2
                ram_ctl.wr_en     = 1'b1;
                ram_ctl.wr_addr   = slot_of(head_reg, idx_ext);
                ram_ctl.wr_data   = rd_data_a;
                ram_ctl.rd_addr_a = slot_of(head_reg, idx_ext + CNT_TWO);
                if (idx_ext + CNT_TWO < count_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = result_reg;
                    out_status_next = status_reg;
                    out_fill_next   = count_reg;
                    out_empty_next  = store_empty;
                    out_front_next  = store_empty ? '0 : rd_data_a;
                    out_back_next   = store_empty ? '0 : rd_data_b;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        hits_reg       <= hits_next;
        result_reg     <= result_next;
        status_reg     <= status_next;
        out_result_reg <= out_result_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_empty_reg  <= out_empty_next;
    end

endmodule

FILE: test/tb_bounded_deque_with_search_erase_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search_erase_top
// Self-checking bench for the bounded deque. Requests come from a queue that
// is filled up front. The queue holds a short directed list: empty pops,
// single-entry pops, a fill to full with overflow on both ends, and a count
// and an erase on duplicates. Then come random requests in fill, drain and
// mixed runs, with operands drawn often from recently pushed values. Each
// accepted request goes through a bench-side deque model. Each response is
// checked field by field against the oldest prediction. Both sides idle at
// random, and the response side stalls twice for a long stretch.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search_erase_top;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1200;
    localparam int RUN_LENGTH   = 40;      // requests per biased random run
    localparam int POOL_SIZE    = 8;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // selectors with no operation behind them
    localparam logic [bdq_pkg::FUNC_W-1:0] FUNC_NOP_LO = 3'd6;
    localparam logic [bdq_pkg::FUNC_W-1:0] FUNC_NOP_HI = 3'd7;

    localparam bdq_pkg::word_t WORD_MAX  = 32'sh7FFF_FFFF;
    localparam bdq_pkg::word_t WORD_MIN  = 32'sh8000_0000;
    localparam bdq_pkg::word_t WORD_MISS = 32'sh0000_3039;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct {
        logic [bdq_pkg::FUNC_W-1:0] func;
        bdq_pkg::word_t             value;
    } request_t;

    typedef struct packed {
        bdq_pkg::word_t               result_value;
        logic [bdq_pkg::STATUS_W-1:0] status;
        logic [bdq_pkg::CNT_W-1:0]    fill_level;
        bdq_pkg::word_t               front_value;
        bdq_pkg::word_t               back_value;
        logic                         is_empty;
    } outcome_t;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search_erase_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    request_t        pending_requests[$];
    outcome_t        expected_outcomes[$];
    bdq_pkg::word_t  recent_pushes[$];

    // bench copy of the deque
    bdq_pkg::word_t             dq_slots [bdq_pkg::DEPTH];
    logic [bdq_pkg::ADDR_W-1:0] dq_head = '0;
    int                         dq_count = 0;

    request_t next_req;
    bit       req_taken = 1'b0;
    int       accepted = 0;
    int       mismatches = 0;
    int       cycles = 0;
    int       hold_left = 0;
    int       holds_done = 0;
    logic     calm;

    assign calm = (accepted >= 500) && (accepted < 700);

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Deque model
    // ------------------------------------------------------------------
    function automatic logic [bdq_pkg::ADDR_W-1:0] slot_of(int offset);
        return dq_head + offset[bdq_pkg::ADDR_W-1:0];
    endfunction

    function automatic outcome_t apply_request(logic [bdq_pkg::FUNC_W-1:0] op,
                                               bdq_pkg::word_t val);
        outcome_t o;
        int       pos;
        int       i;
        o = '0;
        o.status = bdq_pkg::STATUS_OK;
        case (op)
            bdq_pkg::FUNC_PUSH_FRONT:
                if (dq_count >= bdq_pkg::DEPTH)
                    o.status = bdq_pkg::STATUS_OVERFLOW;
                else
                begin
                    dq_head = dq_head - 1'b1;
                    dq_slots[dq_head] = val;
                    dq_count++;
                end
            bdq_pkg::FUNC_PUSH_BACK:
                if (dq_count >= bdq_pkg::DEPTH)
                    o.status = bdq_pkg::STATUS_OVERFLOW;
                else
                begin
                    dq_slots[slot_of(dq_count)] = val;
                    dq_count++;
                end
            bdq_pkg::FUNC_POP_FRONT:
                if (dq_count == 0)
                    o.status = bdq_pkg::STATUS_UNDERFLOW;
                else
                begin
                    o.result_value = dq_slots[dq_head];
                    dq_head = dq_head + 1'b1;
                    dq_count--;
                end
            bdq_pkg::FUNC_POP_BACK:
                if (dq_count == 0)
                    o.status = bdq_pkg::STATUS_UNDERFLOW;
                else
                begin
                    o.result_value = dq_slots[slot_of(dq_count - 1)];
                    dq_count--;
                end
            bdq_pkg::FUNC_COUNT:
                for (i = 0; i < dq_count; i++)
                    if (dq_slots[slot_of(i)] == val)
                        o.result_value = o.result_value + 1;
            bdq_pkg::FUNC_ERASE:
            begin
                pos = -1;
                for (i = 0; i < dq_count && pos < 0; i++)
                    if (dq_slots[slot_of(i)] == val)
                        pos = i;
                if (pos < 0)
                    o.status = bdq_pkg::STATUS_NOT_FOUND;
                else
                begin
                    // close the gap toward the front
                    for (i = pos; i + 1 < dq_count; i++)
                        dq_slots[slot_of(i)] = dq_slots[slot_of(i + 1)];
                    dq_count--;
                end
            end
            default: ;
        endcase
        o.fill_level = dq_count[bdq_pkg::CNT_W-1:0];
        o.is_empty   = (dq_count == 0);
        if (dq_count != 0)
        begin
            o.front_value = dq_slots[dq_head];
            o.back_value  = dq_slots[slot_of(dq_count - 1)];
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    function automatic bdq_pkg::word_t corner_value(int k);
        case (k % 5)
            0:       return '0;
            1:       return -32'sd1;
            2:       return 32'sd1;
            3:       return WORD_MIN;
            default: return WORD_MAX;
        endcase
    endfunction

    function automatic bdq_pkg::word_t pick_operand();
        int r;
        r = $urandom_range(99);
        if (r < 45 && recent_pushes.size() != 0)
            return recent_pushes[$urandom_range(recent_pushes.size() - 1)];
        else if (r < 60)
            return corner_value($urandom_range(4));
        return bdq_pkg::word_t'($urandom);
    endfunction

    task automatic queue_request(logic [bdq_pkg::FUNC_W-1:0] op, bdq_pkg::word_t val);
        request_t r;
        r.func  = op;
        r.value = val;
        pending_requests = {pending_requests, r};
        if (op == bdq_pkg::FUNC_PUSH_FRONT || op == bdq_pkg::FUNC_PUSH_BACK)
        begin
            recent_pushes = {recent_pushes, val};
            if (recent_pushes.size() > POOL_SIZE)
                recent_pushes.delete(0);
        end
    endtask

    initial
    begin : stimulus
        int n;
        int mode;
        int roll;
        int push_cut;
        int pop_cut;
        logic [bdq_pkg::FUNC_W-1:0] op;

        // empty pops, then single-entry pops from each end
        queue_request(bdq_pkg::FUNC_POP_FRONT, bdq_pkg::word_t'($urandom));
        queue_request(bdq_pkg::FUNC_POP_BACK, bdq_pkg::word_t'($urandom));
        queue_request(bdq_pkg::FUNC_PUSH_BACK, WORD_MAX);
        queue_request(bdq_pkg::FUNC_POP_FRONT, '0);
        queue_request(bdq_pkg::FUNC_PUSH_FRONT, WORD_MIN);
        queue_request(bdq_pkg::FUNC_POP_BACK, -32'sd1);
        // fill to full with duplicates, then overflow both ends
        for (n = 0; n < bdq_pkg::DEPTH; n++)
            queue_request(n % 2 ? bdq_pkg::FUNC_PUSH_FRONT : bdq_pkg::FUNC_PUSH_BACK,
                          corner_value(n));
        queue_request(bdq_pkg::FUNC_PUSH_FRONT, WORD_MAX);
        queue_request(bdq_pkg::FUNC_PUSH_BACK, WORD_MIN);
        queue_request(bdq_pkg::FUNC_COUNT, '0);
        queue_request(bdq_pkg::FUNC_ERASE, WORD_MISS);
        queue_request(bdq_pkg::FUNC_ERASE, '0);

        mode = MODE_MIXED;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % RUN_LENGTH == 0)
                mode = $urandom_range(MODE_MIXED);
            case (mode)
                MODE_FILL:  begin push_cut = 55; pop_cut = 70; end
                MODE_DRAIN: begin push_cut = 15; pop_cut = 70; end
                default:    begin push_cut = 35; pop_cut = 65; end
            endcase
            roll = $urandom_range(99);
            if (roll < push_cut)
                op = $urandom_range(1) ? bdq_pkg::FUNC_PUSH_BACK : bdq_pkg::FUNC_PUSH_FRONT;
            else if (roll < pop_cut)
                op = $urandom_range(1) ? bdq_pkg::FUNC_POP_BACK : bdq_pkg::FUNC_POP_FRONT;
            else if (roll < pop_cut + 12)
                op = bdq_pkg::FUNC_COUNT;
            else if (roll < 96)
                op = bdq_pkg::FUNC_ERASE;
            else
                op = $urandom_range(1) ? FUNC_NOP_HI : FUNC_NOP_LO;
            queue_request(op, pick_operand());
        end

        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: moves on only after the current transfer
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.func  <= '0;
            req_ch.value <= '0;
        end
        else if (!req_ch.valid || req_taken)
        begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 25))
            begin
                next_req = pending_requests[0];
                pending_requests.delete(0);
                req_ch.valid <= 1'b1;
                req_ch.func  <= next_req.func;
                req_ch.value <= next_req.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response side: random ready, plus two long holds so the block backs up
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (holds_done < 2 && accepted >= 300 + 600 * holds_done)
            begin
                hold_left    <= HOLD_CYCLES;
                holds_done   <= holds_done + 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check responses first, then predict the new request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        req_taken <= req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.result_value = rsp_ch.result_value;
                got.status       = rsp_ch.status;
                got.fill_level   = rsp_ch.fill_level;
                got.front_value  = rsp_ch.front_value;
                got.back_value   = rsp_ch.back_value;
                got.is_empty     = rsp_ch.is_empty;
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: response with nothing outstanding: res=%0d st=%0d",
                                 $realtime, got.result_value, got.status);
                end
                else
                begin
                    want = expected_outcomes[0];
                    expected_outcomes.delete(0);
                    if (got.result_value !== want.result_value
                        || got.status !== want.status
                        || got.fill_level !== want.fill_level
                        || got.front_value !== want.front_value
                        || got.back_value !== want.back_value
                        || got.is_empty !== want.is_empty)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch exp res=%0d st=%0d fill=%0d front=%0d back=%0d empty=%0b",
                                     $realtime, want.result_value, want.status,
                                     want.fill_level, want.front_value, want.back_value,
                                     want.is_empty);
                            $display("    got res=%0d st=%0d fill=%0d front=%0d back=%0d empty=%0b",
                                     got.result_value, got.status, got.fill_level,
                                     got.front_value, got.back_value, got.is_empty);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                expected_outcomes = {expected_outcomes,
                                     apply_request(req_ch.func, req_ch.value)};
                accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
